[sv/sbq_pkg.sv]
`timescale 1ns / 1ps

package sbq_pkg;

    // Coefficient format and accumulator width are fixed by the number formats.
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 28;
    localparam int ACC_W     = 64;

    // APB register file: five 32-bit registers at byte addresses 0, 4, ..., 16.
    localparam int APB_DW = 32;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_LOAD_DLY,
        ACC_ADD_DLY,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        t_reg_idx coef_sel;
        logic     use_y;
        t_acc_op  acc_op;
    } t_mac_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_ACC_Z1,
        ST_TAKE_Y,
        ST_ADD_Z2,
        ST_SUB_A1,
        ST_TAKE_Z1,
        ST_SUB_A2,
        ST_TAKE_Z2,
        ST_DONE
    } t_state;

endpackage

[sv/sbq_if.sv]
`timescale 1ns / 1ps

interface sbq_in_if #(
    parameter int SAMPLE_WIDTH = 24
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;
    logic                           block_end;

    modport source (output valid, left_in, right_in, block_end, input ready);
    modport sink   (input valid, left_in, right_in, block_end, output ready);
endinterface

interface sbq_out_if #(
    parameter int SAMPLE_WIDTH = 24
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
    logic                           block_end_out;

    modport source (output valid, left_out, right_out, block_end_out, input ready);
    modport sink   (input valid, left_out, right_out, block_end_out, output ready);
endinterface

[sv/sbq_apb_regs.sv]
`timescale 1ns / 1ps

module sbq_apb_regs
    import sbq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_coefs            o_coefs
);

    t_coefs   r_coefs;
    t_reg_idx w_idx;

    assign w_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign o_coefs = r_coefs;

    // Indexes beyond the register list are ignored on write and read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_W'(1) << COEF_FRAC;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_B0:  r_coefs.b0 <= pwdata;
                REG_B1:  r_coefs.b1 <= pwdata;
                REG_B2:  r_coefs.b2 <= pwdata;
                REG_A1:  r_coefs.a1 <= pwdata;
                REG_A2:  r_coefs.a2 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_B0:  prdata = r_coefs.b0;
            REG_B1:  prdata = r_coefs.b1;
            REG_B2:  prdata = r_coefs.b2;
            REG_A1:  prdata = r_coefs.a1;
            REG_A2:  prdata = r_coefs.a2;
            default: prdata = '0;
        endcase
    end

endmodule

[sv/sbq_mac.sv]
`timescale 1ns / 1ps

module sbq_mac
    import sbq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int DELAY_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  t_mac_ctrl                      i_ctrl,
    input  t_coefs                         i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y,
    input  logic signed [DELAY_WIDTH-1:0]  i_dly,
    output logic signed [SAMPLE_WIDTH-1:0] o_y_sat,
    output logic signed [DELAY_WIDTH-1:0]  o_dly_sat
);

    localparam int PROD_W = COEF_W + SAMPLE_WIDTH;

    // The accumulator carries sample plus coefficient fraction bits. A delay value
    // is aligned to it by ALIGN bits; either direction is possible across widths.
    localparam int ALIGN   = (SAMPLE_WIDTH - 1) + COEF_FRAC - (DELAY_WIDTH - 4);
    localparam int ALIGN_L = (ALIGN > 0) ? ALIGN : 0;
    localparam int ALIGN_R = (ALIGN < 0) ? -ALIGN : 0;
    localparam int HPOS_L  = (ALIGN_L > 0) ? ALIGN_L - 1 : 0;
    localparam int HPOS_R  = (ALIGN_R > 0) ? ALIGN_R - 1 : 0;

    localparam logic signed [ACC_W-1:0] HALF_L =
        (ALIGN_L > 0) ? (ACC_W'(1) << HPOS_L) : '0;
    localparam logic signed [ACC_W-1:0] HALF_R =
        (ALIGN_R > 0) ? (ACC_W'(1) << HPOS_R) : '0;
    localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) << (COEF_FRAC - 1);

    localparam logic signed [ACC_W-1:0] Y_HI =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;
    localparam logic signed [ACC_W-1:0] Z_HI =
        {{(ACC_W - DELAY_WIDTH + 1){1'b0}}, {(DELAY_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Z_LO = ~Z_HI;

    logic signed [COEF_W-1:0]       w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_mul_b;
    logic signed [PROD_W-1:0]       w_prod;
    logic signed [ACC_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [ACC_W-1:0]        n_acc;
    logic signed [ACC_W-1:0]        w_dly64;
    logic signed [ACC_W-1:0]        w_dly_rnd;
    logic signed [ACC_W-1:0]        w_dly_al;
    logic signed [ACC_W-1:0]        w_y_rnd;
    logic signed [ACC_W-1:0]        w_y_sh;
    logic signed [ACC_W-1:0]        w_y_sat;
    logic signed [ACC_W-1:0]        w_z_rnd;
    logic signed [ACC_W-1:0]        w_z_sh;
    logic signed [ACC_W-1:0]        w_z_sat;

    always_comb begin
        case (i_ctrl.coef_sel)
            REG_B0:  w_coef = i_coefs.b0;
            REG_B1:  w_coef = i_coefs.b1;
            REG_B2:  w_coef = i_coefs.b2;
            REG_A1:  w_coef = i_coefs.a1;
            REG_A2:  w_coef = i_coefs.a2;
            default: w_coef = i_coefs.b0;
        endcase
    end

    assign w_mul_b = i_ctrl.use_y ? i_y : i_x;
    assign w_prod  = w_coef * w_mul_b;

    // Delay value brought to accumulator precision, rounding half up if it shrinks.
    assign w_dly64   = ACC_W'(i_dly);
    assign w_dly_rnd = w_dly64 + HALF_R;
    assign w_dly_al  = (w_dly_rnd >>> ALIGN_R) << ALIGN_L;

    always_comb begin
        case (i_ctrl.acc_op)
            ACC_LOAD:     n_acc = r_prod;
            ACC_LOAD_DLY: n_acc = r_prod + w_dly_al;
            ACC_ADD_DLY:  n_acc = r_acc + w_dly_al;
            ACC_SUB:      n_acc = r_acc - r_prod;
            default:      n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ACC_W'(w_prod);
        r_acc  <= n_acc;
    end

    // Output sample: round to sample precision, then clip to the sample range.
    assign w_y_rnd = r_acc + HALF_Y;
    assign w_y_sh  = w_y_rnd >>> COEF_FRAC;

    always_comb begin
        if (w_y_sh > Y_HI) begin
            w_y_sat = Y_HI;
        end else if (w_y_sh < Y_LO) begin
            w_y_sat = Y_LO;
        end else begin
            w_y_sat = w_y_sh;
        end
    end

    // New delay value: back to delay precision, then clip to the delay range.
    assign w_z_rnd = r_acc + HALF_L;
    assign w_z_sh  = (w_z_rnd >>> ALIGN_L) << ALIGN_R;

    always_comb begin
        if (w_z_sh > Z_HI) begin
            w_z_sat = Z_HI;
        end else if (w_z_sh < Z_LO) begin
            w_z_sat = Z_LO;
        end else begin
            w_z_sat = w_z_sh;
        end
    end

    assign o_y_sat   = w_y_sat[SAMPLE_WIDTH-1:0];
    assign o_dly_sat = w_z_sat[DELAY_WIDTH-1:0];

endmodule

[sv/stereo_biquad_tdf2_unit.sv]
`timescale 1ns / 1ps

// Stereo biquad in transposed direct form II. Each request carries one left and
// one right Q1.23 sample; both channels share the five Q4.28 coefficients written
// over APB (b0 at 0x00, b1 at 0x04, b2 at 0x08, a1 at 0x0C, a2 at 0x10; a1 and a2
// are subtracted) and each keeps two 48-bit Q4.44 delay registers that reset to
// zero. A single 32 x SAMPLE_WIDTH multiplier and a 64-bit accumulator are stepped
// by a sequencer through eight steps per channel, left then right. A frame runs
// from acceptance through sixteen arithmetic steps to a final step that loads
// the output register, after which ready is raised again. The result waits in
// the output register, while the next request may already be accepted; a new
// result is held back only if the previous one has not been taken. Outputs are
// rounded half up and saturated to the sample range, delay values saturate to
// the delay range, and block_end is passed through unchanged. Coefficients
// should be written only while the block is idle.

module stereo_biquad_tdf2_unit
    import sbq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int DELAY_WIDTH  = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbq_in_if.sink            i_in,
    sbq_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_state    r_state;
    t_state    n_state;
    logic      r_chan;
    logic      n_chan;
    t_mac_ctrl w_ctrl;
    t_coefs    w_coefs;
    logic      w_accept;
    logic      w_take_y;
    logic      w_take_z1;
    logic      w_take_z2;
    logic      w_load_out;

    logic signed [SAMPLE_WIDTH-1:0] r_x_l;
    logic signed [SAMPLE_WIDTH-1:0] r_x_r;
    logic                           r_blk;
    logic signed [SAMPLE_WIDTH-1:0] r_y_l;
    logic signed [SAMPLE_WIDTH-1:0] r_y_r;
    logic signed [DELAY_WIDTH-1:0]  r_z1_l;
    logic signed [DELAY_WIDTH-1:0]  r_z2_l;
    logic signed [DELAY_WIDTH-1:0]  r_z1_r;
    logic signed [DELAY_WIDTH-1:0]  r_z2_r;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_l;
    logic signed [SAMPLE_WIDTH-1:0] r_out_r;
    logic                           r_out_blk;

    logic signed [SAMPLE_WIDTH-1:0] w_x;
    logic signed [SAMPLE_WIDTH-1:0] w_y;
    logic signed [DELAY_WIDTH-1:0]  w_z1;
    logic signed [DELAY_WIDTH-1:0]  w_z2;
    logic signed [DELAY_WIDTH-1:0]  w_dly;
    logic signed [SAMPLE_WIDTH-1:0] w_y_sat;
    logic signed [DELAY_WIDTH-1:0]  w_dly_sat;

    sbq_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (w_coefs)
    );

    // The channel bit picks which sample and which pair of delay registers the
    // shared unit works on. The first accumulate step reads z1, the second z2.
    assign w_x   = r_chan ? r_x_r  : r_x_l;
    assign w_y   = r_chan ? r_y_r  : r_y_l;
    assign w_z1  = r_chan ? r_z1_r : r_z1_l;
    assign w_z2  = r_chan ? r_z2_r : r_z2_l;
    assign w_dly = (r_state == ST_ADD_Z2) ? w_z2 : w_z1;

    sbq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DELAY_WIDTH  (DELAY_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_coefs   (w_coefs),
        .i_x       (w_x),
        .i_y       (w_y),
        .i_dly     (w_dly),
        .o_y_sat   (w_y_sat),
        .o_dly_sat (w_dly_sat)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    // The multiplier result lands in its register at the end of the step that selects
    // its operands, so each product is requested in the step before its use.
    // The feedback product a1*y can start only once y has been registered.
    always_comb begin
        n_state         = r_state;
        n_chan          = r_chan;
        w_ctrl.coef_sel = REG_B0;
        w_ctrl.use_y    = 1'b0;
        w_ctrl.acc_op   = ACC_HOLD;
        w_take_y        = 1'b0;
        w_take_z1       = 1'b0;
        w_take_z2       = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_MUL_B0;
                    n_chan  = 1'b0;
                end
            end
            ST_MUL_B0: begin
                w_ctrl.coef_sel = REG_B0;
                n_state         = ST_ACC_Z1;
            end
            ST_ACC_Z1: begin
                w_ctrl.coef_sel = REG_B1;
                w_ctrl.acc_op   = ACC_LOAD_DLY;
                n_state         = ST_TAKE_Y;
            end
            ST_TAKE_Y: begin
                w_take_y      = 1'b1;
                w_ctrl.acc_op = ACC_LOAD;
                n_state       = ST_ADD_Z2;
            end
            ST_ADD_Z2: begin
                w_ctrl.coef_sel = REG_A1;
                w_ctrl.use_y    = 1'b1;
                w_ctrl.acc_op   = ACC_ADD_DLY;
                n_state         = ST_SUB_A1;
            end
            ST_SUB_A1: begin
                w_ctrl.coef_sel = REG_B2;
                w_ctrl.acc_op   = ACC_SUB;
                n_state         = ST_TAKE_Z1;
            end
            ST_TAKE_Z1: begin
                w_take_z1       = 1'b1;
                w_ctrl.coef_sel = REG_A2;
                w_ctrl.use_y    = 1'b1;
                w_ctrl.acc_op   = ACC_LOAD;
                n_state         = ST_SUB_A2;
            end
            ST_SUB_A2: begin
                w_ctrl.acc_op = ACC_SUB;
                n_state       = ST_TAKE_Z2;
            end
            ST_TAKE_Z2: begin
                w_take_z2 = 1'b1;
                if (!r_chan) begin
                    n_chan  = 1'b1;
                    n_state = ST_MUL_B0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x_l <= i_in.left_in;
            r_x_r <= i_in.right_in;
            r_blk <= i_in.block_end;
        end
        if (w_take_y) begin
            if (r_chan) begin
                r_y_r <= w_y_sat;
            end else begin
                r_y_l <= w_y_sat;
            end
        end
        if (w_load_out) begin
            r_out_l   <= r_y_l;
            r_out_r   <= r_y_r;
            r_out_blk <= r_blk;
        end
    end

    // Delay registers are filter state and carry across blocks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1_l <= '0;
            r_z2_l <= '0;
            r_z1_r <= '0;
            r_z2_r <= '0;
        end else begin
            if (w_take_z1) begin
                if (r_chan) begin
                    r_z1_r <= w_dly_sat;
                end else begin
                    r_z1_l <= w_dly_sat;
                end
            end
            if (w_take_z2) begin
                if (r_chan) begin
                    r_z2_r <= w_dly_sat;
                end else begin
                    r_z2_l <= w_dly_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.left_out      = r_out_l;
    assign o_out.right_out     = r_out_r;
    assign o_out.block_end_out = r_out_blk;

`ifndef SYNTHESIS
    // An accepted request always starts on the left channel.
    a_start_left : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MUL_B0 && !r_chan))
        else $error("sequencer did not start the left channel after a request");

    // A new result appears only when the sequencer has finished both channels.
    a_out_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("output became valid outside the final step");

    // A result that has not been taken holds the sequencer in its final step.
    a_done_waits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_out.ready) |=> (r_state == ST_DONE))
        else $error("finished frame overwrote an untaken result");

    // The left first delay register changes only in its own update step.
    a_z1_left_update : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_z1_l)) |-> $past(r_state == ST_TAKE_Z1 && !r_chan))
        else $error("left z1 changed outside its update step");
`endif

endmodule
